FILE: rtl/cfd_pkg.sv
// ============================================================================
// cfd_pkg: shared types and constants for the block stream deframer
// Field widths, header constants, status codes, the parser phase encoding,
// and the structs that carry queued bytes and configuration writes to the parser.
// ============================================================================
package cfd_pkg;

  localparam int BYTE_W = 8;
  localparam int SIZE_W = 16;
  localparam int LEN_W  = 25;

  // Lead byte that opens a five-byte header.
  localparam logic [BYTE_W-1:0] LONG_MARK = 8'hFF;

  // Decompressed block size assumed by a two-byte header, capped at the output still owed.
  localparam logic [SIZE_W-1:0] DEFAULT_BLOCK_SIZE = 16'd32768;

  // Largest legal stream length in either direction.
  localparam logic [LEN_W-1:0] MAX_ENTRY_BYTES = 25'd16777216;

  // Header sizes, counting the lead byte.
  localparam logic [LEN_W-1:0] LONG_HDR_BYTES  = 25'd5;
  localparam logic [LEN_W-1:0] SHORT_HDR_BYTES = 25'd2;

  // Configuration register indexes.
  localparam logic REG_INPUT_LENGTH  = 1'b0;
  localparam logic REG_OUTPUT_LENGTH = 1'b1;

  // Stream status reported with every result.
  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_LEAD = 6'b000001,
    PH_DHI  = 6'b000010,
    PH_DLO  = 6'b000100,
    PH_CHI  = 6'b001000,
    PH_CLO  = 6'b010000,
    PH_PAY  = 6'b100000
  } phase_t;

  // One classified input byte held in the queue.
  typedef struct packed {
    logic              is_mark;
    logic [BYTE_W-1:0] data;
  } qentry_t;

  // Configuration write as seen by the parser.
  typedef struct packed {
    logic             we;
    logic             index;
    logic [LEN_W-1:0] data;
  } cfg_wr_t;

  // A length register is legal when nonzero and no larger than the maximum.
  function automatic logic len_ok(input logic [LEN_W-1:0] v);
    len_ok = (v != '0) && (v <= MAX_ENTRY_BYTES);
  endfunction

endpackage

FILE: rtl/cfd_front.sv
// ============================================================================
// cfd_front: input acceptance, byte classification and queue
// Takes stream bytes, tags header lead marks, and holds them in a short
// queue so the parser can stall without blocking the input side at once.
// ============================================================================
module cfd_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_byte,
  output logic               q_valid,
  output cfd_pkg::qentry_t   q_head,
  input  logic               q_pop
);
  import cfd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qentry_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;
  qentry_t         entry_in;

  // Classify the incoming byte.
  always_comb begin
    entry_in.data    = s_byte;
    entry_in.is_mark = (s_byte == LONG_MARK);
  end

  assign s_tready = (count != CntW'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cfd_back.sv
// ============================================================================
// cfd_back: header parser, length checks and result register
// Walks the block headers, checks sizes against the remaining input and
// owed output, passes payload bytes on, and holds each result for the sink.
// ============================================================================
module cfd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cfd_pkg::cfg_wr_t            cfg,
  input  logic                        q_valid,
  input  cfd_pkg::qentry_t            q_head,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cfd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_has,
  output cfd_pkg::status_t            out_status
);
  import cfd_pkg::*;

  // Configuration and its legality flags.
  logic [LEN_W-1:0]  input_length;
  logic [LEN_W-1:0]  output_length;
  logic              in_ok;
  logic              out_ok;

  // Parser state.
  phase_t            phase, phase_next;
  status_t           finished, finished_next;
  logic              long_header, long_header_next;
  logic [SIZE_W-1:0] csize, csize_next;
  logic [SIZE_W-1:0] dsize, dsize_next;
  logic [SIZE_W-1:0] payload_left, payload_left_next;
  logic [LEN_W-1:0]  input_left, input_left_next;
  logic [LEN_W-1:0]  output_left, output_left_next;

  logic              fire;
  logic              emit;
  logic [BYTE_W-1:0] res_byte;
  logic              res_has;
  logic [SIZE_W-1:0] csize_full;
  logic [SIZE_W-1:0] dsize_short;
  logic [SIZE_W-1:0] dsize_eff;

  // A queued byte is taken when the result register is free or draining.
  assign fire  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = fire;
  assign emit  = fire && (finished == ST_RUN);

  assign csize_full  = {csize[15:8], q_head.data};
  assign dsize_short = (output_left < {9'b0, DEFAULT_BLOCK_SIZE}) ?
                       output_left[SIZE_W-1:0] : DEFAULT_BLOCK_SIZE;
  assign dsize_eff   = long_header ? dsize : dsize_short;

  // Next-state logic for one byte.
  always_comb begin
    phase_next        = phase;
    finished_next     = finished;
    long_header_next  = long_header;
    csize_next        = csize;
    dsize_next        = dsize;
    payload_left_next = payload_left;
    input_left_next   = input_left;
    output_left_next  = output_left;
    res_byte          = '0;
    res_has           = 1'b0;
    if (emit) begin
      if (!(in_ok && out_ok)) begin
        finished_next = ST_ERR;
      end else begin
        case (phase)
          PH_LEAD: begin
            if (q_head.is_mark) begin
              if (input_left < LONG_HDR_BYTES) begin
                finished_next = ST_ERR;
              end else begin
                long_header_next = 1'b1;
                phase_next       = PH_DHI;
                input_left_next  = input_left - 1'b1;
              end
            end else begin
              if (input_left < SHORT_HDR_BYTES) begin
                finished_next = ST_ERR;
              end else begin
                long_header_next = 1'b0;
                csize_next       = {q_head.data, 8'h00};
                phase_next       = PH_CLO;
                input_left_next  = input_left - 1'b1;
              end
            end
          end
          PH_DHI: begin
            dsize_next      = {q_head.data, 8'h00};
            phase_next      = PH_DLO;
            input_left_next = input_left - 1'b1;
          end
          PH_DLO: begin
            dsize_next      = {dsize[15:8], q_head.data};
            phase_next      = PH_CHI;
            input_left_next = input_left - 1'b1;
          end
          PH_CHI: begin
            csize_next      = {q_head.data, 8'h00};
            phase_next      = PH_CLO;
            input_left_next = input_left - 1'b1;
          end
          PH_CLO: begin
            // Last header byte: the size must fit what remains after it.
            csize_next      = csize_full;
            dsize_next      = dsize_eff;
            input_left_next = input_left - 1'b1;
            if ((csize_full == '0) || (dsize_eff == '0) ||
                ({9'b0, csize_full} >= input_left) ||
                ({9'b0, dsize_eff} > output_left)) begin
              finished_next = ST_ERR;
            end else begin
              payload_left_next = csize_full;
              phase_next        = PH_PAY;
            end
          end
          PH_PAY: begin
            res_byte          = q_head.data;
            res_has           = 1'b1;
            input_left_next   = input_left - 1'b1;
            payload_left_next = payload_left - 1'b1;
            if (payload_left == SIZE_W'(1)) begin
              // End of block: settle the output owed.
              output_left_next = output_left - {9'b0, dsize};
              phase_next       = PH_LEAD;
              if (output_left_next == '0) begin
                finished_next = ST_DONE;
              end else if (input_left == LEN_W'(1)) begin
                finished_next = ST_ERR;
              end
            end
          end
          default: begin
            phase_next = PH_LEAD;
          end
        endcase
      end
    end
  end

  // Parser registers; a configuration write restarts the parse.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_length  <= LEN_W'(1);
      output_length <= LEN_W'(1);
      in_ok         <= 1'b1;
      out_ok        <= 1'b1;
      phase         <= PH_LEAD;
      finished      <= ST_RUN;
      long_header   <= 1'b0;
      csize         <= '0;
      dsize         <= '0;
      payload_left  <= '0;
      input_left    <= LEN_W'(1);
      output_left   <= LEN_W'(1);
    end else if (cfg.we) begin
      phase        <= PH_LEAD;
      finished     <= ST_RUN;
      long_header  <= 1'b0;
      csize        <= '0;
      dsize        <= '0;
      payload_left <= '0;
      if (cfg.index == REG_INPUT_LENGTH) begin
        input_length <= cfg.data;
        in_ok        <= len_ok(cfg.data);
        input_left   <= cfg.data;
        output_left  <= output_length;
      end else begin
        output_length <= cfg.data;
        out_ok        <= len_ok(cfg.data);
        input_left    <= input_length;
        output_left   <= cfg.data;
      end
    end else begin
      phase        <= phase_next;
      finished     <= finished_next;
      long_header  <= long_header_next;
      csize        <= csize_next;
      dsize        <= dsize_next;
      payload_left <= payload_left_next;
      input_left   <= input_left_next;
      output_left  <= output_left_next;
    end
  end

  // Result register toward the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= res_byte;
      out_has    <= res_has;
      out_status <= finished_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A finished stream stays finished until the next configuration write.
  a_sticky_finish: assert property (@(posedge clk) disable iff (rst)
    (finished != ST_RUN) && !cfg.we |=> finished == $past(finished))
    else $error("finished status changed without a configuration write");

  // Payload phase always has at least one payload byte pending.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (payload_left != '0))
    else $error("payload phase with no payload bytes left");

  // Inside a block the remaining input never runs dry.
  a_input_covered: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_LEAD) && (finished == ST_RUN) |-> (input_left != '0))
    else $error("block in progress with no input left");

  // A byte taken after the end produces no result.
  a_no_result_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && (finished != ST_RUN) && m_tready |=> !m_tvalid)
    else $error("result produced after the stream finished");
`endif

endmodule

FILE: rtl/compressed_block_stream_deframer_core.sv
// ============================================================================
// compressed_block_stream_deframer_core: block header stripper
// Parses a framed compressed byte stream, checks each block header against
// the configured lengths, and forwards payload bytes with a running status.
//
//   Channel  Direction  Contents
//   s_*      in         one framed stream byte per transaction
//   m_*      out        payload byte, status; has_data flag in tuser
//   cfg_*    in         register index and 25-bit length value
//
// One byte per cycle is sustained while the sink keeps m_tready high; each
// accepted byte is written into the queue, then the parser step registers
// its result in the result register toward the sink.
// Reset is synchronous; it sets both lengths to 1 and empties the queue.
// The input queue of FIFO_DEPTH bytes absorbs stalls from the result side.
// Bytes taken after the stream has finished are dropped without a result.
// ============================================================================
module compressed_block_stream_deframer_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // [7:0] payload_byte, [9:8] status, rest zero
  output logic        m_tuser,     // [0] has_data
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data
);
  import cfd_pkg::*;

  logic              q_valid;
  logic              q_pop;
  qentry_t           q_head;
  cfg_wr_t           cfg;
  logic [BYTE_W-1:0] out_byte;
  logic              out_has;
  status_t           out_status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg.we    = cfg_valid && cfg_ready;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  cfd_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_byte   (s_tdata),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  cfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_byte   (out_byte),
    .out_has    (out_has),
    .out_status (out_status)
  );

  // Pack the result fields.
  assign m_tdata = {6'b0, out_status, out_byte};
  assign m_tuser = out_has;

endmodule
